// ----- design/counting_bloom_filter_core_macros.svh -----
// ----------------------------------------------------------------------------
// counting bloom filter assertion macros
// shared property forms for the core, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef COUNTING_BLOOM_FILTER_CORE_MACROS_SVH
`define COUNTING_BLOOM_FILTER_CORE_MACROS_SVH

// condition implies property in the same cycle
`define CBF_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// condition implies property in the following cycle
`define CBF_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ----- design/cbf_pkg.sv -----
// ----------------------------------------------------------------------------
// cbf_pkg
// constants, types and helpers of the counting bloom filter core
// ----------------------------------------------------------------------------
`default_nettype none

package cbf_pkg;

  localparam int unsigned COUNTER_DEPTH = 4096;
  localparam int unsigned ADDR_W        = $clog2(COUNTER_DEPTH);
  localparam int unsigned CNT_W         = ADDR_W + 1;
  localparam int unsigned MAX_PROBES    = 16;
  localparam int unsigned PROBE_W       = $clog2(MAX_PROBES + 1);
  localparam int unsigned KEY_BYTES     = 16;

  localparam int unsigned MOD_BITS      = 4;
  localparam int unsigned MOD_STEPS     = 64 / MOD_BITS;
  localparam int unsigned MOD_CNT_W     = $clog2(MOD_STEPS);

  localparam logic [63:0] MM_C1  = 64'h87c37b91114253d5;
  localparam logic [63:0] MM_C2  = 64'h4cf5ad432745937f;
  localparam logic [63:0] MIX_A  = 64'h0000000052dce729;
  localparam logic [63:0] MIX_B  = 64'h0000000038495ab5;
  localparam logic [63:0] FM_1   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FM_2   = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] SEED_A = 64'h1234567890abcdef;
  localparam logic [63:0] SEED_B = 64'hfedcba0987654321;
  localparam logic [7:0]  COUNTER_MAX = 8'hff;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    CFG_HASH_COUNT    = 1'b0,
    CFG_COUNTER_COUNT = 1'b1
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR,
    S_L1M1, S_L1M2, S_L2M1, S_L2M2,
    S_MIX1, S_MIX2, S_MIX3, S_MIX4, S_MIX5, S_MIX6,
    S_FA1, S_FA2, S_FB1, S_FB2, S_FIN,
    S_MODA, S_MODB, S_MODW,
    S_PRD, S_PCHK, S_PADV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
    return (v << r) | (v >> (64 - r));
  endfunction

  function automatic logic [63:0] xs33(input logic [63:0] v);
    return v ^ (v >> 33);
  endfunction

endpackage

`default_nettype wire

// ----- design/cbf_mul64.sv -----
// ----------------------------------------------------------------------------
// cbf_mul64
// low 64 bits of a 64x64 product from one 32x32 multiplier in three partial products
// ----------------------------------------------------------------------------
`default_nettype none

module cbf_mul64 (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [63:0]         a,
  input  wire logic [63:0]         b,
  output logic [63:0]              product,
  output cbf_pkg::unit_stat_t      stat
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LL   = 2'd1;
  localparam logic [1:0] PH_LH   = 2'd2;
  localparam logic [1:0] PH_HL   = 2'd3;

  logic [1:0]  phase;
  logic        done;
  logic [63:0] opa, opb, acc;
  logic [31:0] pa, pb;
  logic [63:0] part;

  always_comb begin
    pa = opa[31:0];
    pb = opb[31:0];
    unique case (phase)
      PH_LH:   pb = opb[63:32];
      PH_HL:   pa = opa[63:32];
      default: ;
    endcase
    part = {32'd0, pa} * {32'd0, pb};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        PH_IDLE: if (start) phase <= PH_LL;
        PH_LL:   phase <= PH_LH;
        PH_LH:   phase <= PH_HL;
        PH_HL: begin
          phase <= PH_IDLE;
          done  <= 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase == PH_IDLE && start) begin
      opa <= a;
      opb <= b;
    end
    if (phase == PH_LL) acc <= part;
    else if (phase != PH_IDLE) acc <= acc + {part[31:0], 32'd0};
  end

  assign product   = acc;
  assign stat.busy = (phase != PH_IDLE);
  assign stat.done = done;

endmodule

`default_nettype wire

// ----- design/cbf_mod.sv -----
// ----------------------------------------------------------------------------
// cbf_mod
// remainder of a 64-bit value by the counter modulus, MOD_BITS dividend bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module cbf_mod (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [63:0]                 dividend,
  input  wire logic [cbf_pkg::CNT_W-1:0]   divisor,
  output logic [cbf_pkg::ADDR_W-1:0]       remainder,
  output cbf_pkg::unit_stat_t              stat
);

  logic                            busy, done;
  logic [cbf_pkg::MOD_CNT_W-1:0]   cnt;
  logic [63:0]                     dvd;
  logic [cbf_pkg::ADDR_W-1:0]      rem, rem_next;

  always_comb begin
    logic [cbf_pkg::CNT_W-1:0] t;
    rem_next = rem;
    for (int j = 0; j < cbf_pkg::MOD_BITS; j++) begin
      t = {rem_next, dvd[63-j]};
      if (t >= divisor) t = t - divisor;
      rem_next = t[cbf_pkg::ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == cbf_pkg::MOD_CNT_W'(cbf_pkg::MOD_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd << cbf_pkg::MOD_BITS;
      rem <= rem_next;
    end
  end

  assign remainder = rem;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// ----- design/counting_bloom_filter_core.sv -----
// ----------------------------------------------------------------------------
// counting_bloom_filter_core
// counting bloom filter with 8-bit saturating counters and murmur3 double hashing
// ----------------------------------------------------------------------------
// One item is taken at a time; tready is high only while the core is idle.
// An insert, query or remove runs twelve 64-bit multiplies on one shared
// 32x32 multiplier (key lanes, then finalization of both seeds), the mixing
// steps of each seed (more of them for a full 16-byte key), three remainder
// runs on the shared 4-bit-per-cycle remainder unit (both hashes and 2^64
// mod m), and a counter ram read-modify-write per probe. A query or remove
// that meets a zero counter stops early. Clear sweeps the 4096-entry
// counter ram, one entry a cycle; the same sweep runs after reset, so no
// item is taken until it ends (configuration writes are taken at any time).
// The result sits in an output register, so the next item is taken while a
// result waits for its transfer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "counting_bloom_filter_core_macros.svh"

module counting_bloom_filter_core (
  input  wire logic         clk,
  input  wire logic         rst,
  // config write port
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [12:0]  cfg_data,
  // input items
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [135:0] s_axis_tdata,  // key_low[63:0], key_high[127:64],
                                           // key_length[132:128], zero pad
  input  wire logic [1:0]   s_axis_tuser,  // opcode
  // results
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [39:0]       m_axis_tdata   // may_contain[0], remove_ok[1],
                                           // element_count[33:2], zero pad
);

  localparam int unsigned AW = cbf_pkg::ADDR_W;
  localparam int unsigned CW = cbf_pkg::CNT_W;
  localparam int unsigned PW = cbf_pkg::PROBE_W;

  cbf_pkg::state_t state, state_next;

  // configuration
  logic [4:0]    hash_count;
  logic [12:0]   counter_count;
  logic [PW-1:0] k_eff;
  logic [CW-1:0] m_eff;

  // item and hash state
  cbf_pkg::op_t op;
  logic [63:0]  key_lo, key_hi;
  logic [4:0]   key_len;
  logic [63:0]  x, l1, l2, a, b, ha, hb, s;
  logic         sel, carry;
  logic [AW-1:0] ham, hbm, wm, idx;
  logic [PW-1:0] i;
  logic          may, rok;
  logic [31:0]   elements, elements_next;

  // clearing sweep
  logic [AW-1:0] clr_addr;
  logic          clr_op;

  // results
  logic          out_valid, out_may, out_rok;
  logic [31:0]   out_count;

  // input decode
  cbf_pkg::op_t in_op;
  logic [4:0]   in_len;
  logic [63:0]  in_lo_m, in_hi_m;
  logic         accept;

  // shared units
  logic                 mul_start, mod_start;
  logic [63:0]          mul_a, mul_b, mul_p, mod_dvd;
  logic [AW-1:0]        mod_rem;
  cbf_pkg::unit_stat_t  mul_st, mod_st;

  // counter ram
  logic [7:0]    counters [cbf_pkg::COUNTER_DEPTH];
  logic [7:0]    rd_data, mem_wdata;
  logic [AW-1:0] mem_addr;
  logic          mem_we;

  // probe arithmetic
  logic [CW-1:0] step_sum, step_red, corr, wm_plus;
  logic [64:0]   s_sum;
  logic          full_key, probe_stop;
  logic [63:0]   seed;

  assign accept = s_axis_tvalid && s_axis_tready;

  // clamp registers to their usable ranges
  always_comb begin
    k_eff = (hash_count > 5'(cbf_pkg::MAX_PROBES)) ? PW'(cbf_pkg::MAX_PROBES)
                                                   : PW'(hash_count);
    if (counter_count == '0) m_eff = CW'(1);
    else if (counter_count > 13'(cbf_pkg::COUNTER_DEPTH)) m_eff = CW'(cbf_pkg::COUNTER_DEPTH);
    else m_eff = CW'(counter_count);
  end

  // key bytes past the length read as zero
  always_comb begin
    in_op  = cbf_pkg::op_t'(s_axis_tuser);
    in_len = (s_axis_tdata[132:128] > 5'(cbf_pkg::KEY_BYTES)) ? 5'(cbf_pkg::KEY_BYTES)
                                                             : s_axis_tdata[132:128];
    for (int j = 0; j < 8; j++) begin
      in_lo_m[8*j +: 8] = (in_len > 5'(j))     ? s_axis_tdata[8*j +: 8]      : 8'd0;
      in_hi_m[8*j +: 8] = (in_len > 5'(j + 8)) ? s_axis_tdata[64 + 8*j +: 8] : 8'd0;
    end
  end

  assign full_key = (key_len == 5'(cbf_pkg::KEY_BYTES));
  assign seed     = sel ? cbf_pkg::SEED_B : cbf_pkg::SEED_A;

  // next probe index: add hb mod m, then take out 2^64 mod m on a wrap
  always_comb begin
    step_sum = {1'b0, idx} + {1'b0, hbm};
    step_red = (step_sum >= m_eff) ? step_sum - m_eff : step_sum;
    corr     = ({1'b0, idx} >= {1'b0, wm}) ? {1'b0, idx} - {1'b0, wm}
                                           : {1'b0, idx} + m_eff - {1'b0, wm};
    s_sum    = {1'b0, s} + {1'b0, hb};
    wm_plus  = CW'(mod_rem) + 1'b1;
  end

  assign probe_stop = ((op != cbf_pkg::OP_INSERT) && (rd_data == 8'd0)) ||
                      ((i + 1'b1) == k_eff);

  // element count after the operation
  always_comb begin
    elements_next = elements;
    unique case (op)
      cbf_pkg::OP_INSERT: if (elements != 32'hffff_ffff) elements_next = elements + 1'b1;
      cbf_pkg::OP_REMOVE: if (rok && elements != 32'd0) elements_next = elements - 1'b1;
      cbf_pkg::OP_CLEAR:  elements_next = 32'd0;
      cbf_pkg::OP_QUERY:  ;
    endcase
  end

  // sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      cbf_pkg::S_IDLE:
        if (s_axis_tvalid)
          state_next = (in_op == cbf_pkg::OP_CLEAR) ? cbf_pkg::S_CLEAR : cbf_pkg::S_L1M1;
      cbf_pkg::S_CLEAR:
        if (clr_addr == AW'(cbf_pkg::COUNTER_DEPTH - 1))
          state_next = clr_op ? cbf_pkg::S_DONE : cbf_pkg::S_IDLE;
      cbf_pkg::S_L1M1: if (mul_st.done) state_next = cbf_pkg::S_L1M2;
      cbf_pkg::S_L1M2: if (mul_st.done) state_next = cbf_pkg::S_L2M1;
      cbf_pkg::S_L2M1: if (mul_st.done) state_next = cbf_pkg::S_L2M2;
      cbf_pkg::S_L2M2: if (mul_st.done) state_next = cbf_pkg::S_MIX1;
      cbf_pkg::S_MIX1: state_next = full_key ? cbf_pkg::S_MIX2 : cbf_pkg::S_MIX5;
      cbf_pkg::S_MIX2: state_next = cbf_pkg::S_MIX3;
      cbf_pkg::S_MIX3: state_next = cbf_pkg::S_MIX4;
      cbf_pkg::S_MIX4: state_next = cbf_pkg::S_MIX5;
      cbf_pkg::S_MIX5: state_next = cbf_pkg::S_MIX6;
      cbf_pkg::S_MIX6: state_next = cbf_pkg::S_FA1;
      cbf_pkg::S_FA1:  if (mul_st.done) state_next = cbf_pkg::S_FA2;
      cbf_pkg::S_FA2:  if (mul_st.done) state_next = cbf_pkg::S_FB1;
      cbf_pkg::S_FB1:  if (mul_st.done) state_next = cbf_pkg::S_FB2;
      cbf_pkg::S_FB2:  if (mul_st.done) state_next = cbf_pkg::S_FIN;
      cbf_pkg::S_FIN:  state_next = sel ? cbf_pkg::S_MODA : cbf_pkg::S_MIX1;
      cbf_pkg::S_MODA: if (mod_st.done) state_next = cbf_pkg::S_MODB;
      cbf_pkg::S_MODB: if (mod_st.done) state_next = cbf_pkg::S_MODW;
      cbf_pkg::S_MODW:
        if (mod_st.done)
          state_next = (k_eff == '0) ? cbf_pkg::S_DONE : cbf_pkg::S_PRD;
      cbf_pkg::S_PRD:  state_next = cbf_pkg::S_PCHK;
      cbf_pkg::S_PCHK: state_next = probe_stop ? cbf_pkg::S_DONE : cbf_pkg::S_PADV;
      cbf_pkg::S_PADV: state_next = cbf_pkg::S_PRD;
      cbf_pkg::S_DONE: if (!out_valid || m_axis_tready) state_next = cbf_pkg::S_IDLE;
      default:         state_next = cbf_pkg::S_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    s_axis_tready = 1'b0;
    mul_start     = 1'b0;
    mul_a         = x;
    mul_b         = cbf_pkg::MM_C1;
    mod_start     = 1'b0;
    mod_dvd       = ha;
    mem_we        = 1'b0;
    mem_addr      = idx;
    mem_wdata     = rd_data;
    unique case (state)
      cbf_pkg::S_IDLE: s_axis_tready = 1'b1;
      cbf_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = 8'd0;
      end
      cbf_pkg::S_L1M1: begin mul_a = key_lo; mul_b = cbf_pkg::MM_C1; end
      cbf_pkg::S_L1M2: begin mul_a = x;      mul_b = cbf_pkg::MM_C2; end
      cbf_pkg::S_L2M1: begin mul_a = key_hi; mul_b = cbf_pkg::MM_C2; end
      cbf_pkg::S_L2M2: begin mul_a = x;      mul_b = cbf_pkg::MM_C1; end
      cbf_pkg::S_FA1:  begin mul_a = cbf_pkg::xs33(a); mul_b = cbf_pkg::FM_1; end
      cbf_pkg::S_FA2:  begin mul_a = cbf_pkg::xs33(a); mul_b = cbf_pkg::FM_2; end
      cbf_pkg::S_FB1:  begin mul_a = cbf_pkg::xs33(b); mul_b = cbf_pkg::FM_1; end
      cbf_pkg::S_FB2:  begin mul_a = cbf_pkg::xs33(b); mul_b = cbf_pkg::FM_2; end
      cbf_pkg::S_MODA: mod_dvd = ha;
      cbf_pkg::S_MODB: mod_dvd = hb;
      cbf_pkg::S_MODW: mod_dvd = 64'hffff_ffff_ffff_ffff;
      cbf_pkg::S_PCHK: begin
        if (op == cbf_pkg::OP_INSERT) begin
          mem_we    = (rd_data != cbf_pkg::COUNTER_MAX);
          mem_wdata = rd_data + 1'b1;
        end else if (op == cbf_pkg::OP_REMOVE) begin
          mem_we    = (rd_data != 8'd0);
          mem_wdata = rd_data - 1'b1;
        end
      end
      default: ;
    endcase
    // launch a unit whenever its state is entered and it is free
    if (state == cbf_pkg::S_L1M1 || state == cbf_pkg::S_L1M2 ||
        state == cbf_pkg::S_L2M1 || state == cbf_pkg::S_L2M2 ||
        state == cbf_pkg::S_FA1  || state == cbf_pkg::S_FA2  ||
        state == cbf_pkg::S_FB1  || state == cbf_pkg::S_FB2)
      mul_start = !mul_st.busy && !mul_st.done;
    if (state == cbf_pkg::S_MODA || state == cbf_pkg::S_MODB || state == cbf_pkg::S_MODW)
      mod_start = !mod_st.busy && !mod_st.done;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cbf_pkg::S_CLEAR;
      clr_addr      <= '0;
      clr_op        <= 1'b0;
      out_valid     <= 1'b0;
      elements      <= 32'd0;
      hash_count    <= 5'd7;
      counter_count <= 13'(cbf_pkg::COUNTER_DEPTH);
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cbf_pkg::cfg_idx_t'(cfg_index))
          cbf_pkg::CFG_HASH_COUNT:    hash_count    <= cfg_data[4:0];
          cbf_pkg::CFG_COUNTER_COUNT: counter_count <= cfg_data;
        endcase
      end
      if (accept) begin
        clr_addr <= '0;
        clr_op   <= 1'b1;
      end else if (state == cbf_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      if (state == cbf_pkg::S_DONE && (!out_valid || m_axis_tready)) begin
        out_valid <= 1'b1;
        elements  <= elements_next;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= in_op;
      key_lo  <= in_lo_m;
      key_hi  <= in_hi_m;
      key_len <= in_len;
      sel     <= 1'b0;
      may     <= (in_op == cbf_pkg::OP_QUERY);
      rok     <= (in_op == cbf_pkg::OP_REMOVE);
    end
    unique case (state)
      cbf_pkg::S_L1M1: if (mul_st.done) x  <= cbf_pkg::rotl64(mul_p, 31);
      cbf_pkg::S_L1M2: if (mul_st.done) l1 <= mul_p;
      cbf_pkg::S_L2M1: if (mul_st.done) x  <= cbf_pkg::rotl64(mul_p, 33);
      cbf_pkg::S_L2M2: if (mul_st.done) l2 <= mul_p;
      cbf_pkg::S_MIX1: begin
        if (full_key) begin
          a <= cbf_pkg::rotl64(seed ^ l1, 27) + seed;
          b <= seed;
        end else begin
          a <= seed ^ ((key_len != 5'd0) ? l1 : 64'd0);
          b <= seed ^ ((key_len > 5'd8) ? l2 : 64'd0);
        end
      end
      cbf_pkg::S_MIX2: a <= (a << 2) + a + cbf_pkg::MIX_A;
      cbf_pkg::S_MIX3: b <= cbf_pkg::rotl64(b ^ l2, 31) + a;
      cbf_pkg::S_MIX4: b <= (b << 2) + b + cbf_pkg::MIX_B;
      cbf_pkg::S_MIX5: begin
        a <= (a ^ 64'(key_len)) + (b ^ 64'(key_len));
        b <= b ^ 64'(key_len);
      end
      cbf_pkg::S_MIX6: b <= b + a;
      cbf_pkg::S_FA1:  if (mul_st.done) a <= mul_p;
      cbf_pkg::S_FA2:  if (mul_st.done) a <= cbf_pkg::xs33(mul_p);
      cbf_pkg::S_FB1:  if (mul_st.done) b <= mul_p;
      cbf_pkg::S_FB2:  if (mul_st.done) b <= cbf_pkg::xs33(mul_p);
      cbf_pkg::S_FIN: begin
        if (sel) hb <= a + b;
        else     ha <= a + b;
        sel <= 1'b1;
      end
      cbf_pkg::S_MODA: if (mod_st.done) ham <= mod_rem;
      cbf_pkg::S_MODB: if (mod_st.done) hbm <= mod_rem;
      cbf_pkg::S_MODW: begin
        if (mod_st.done) begin
          wm  <= (wm_plus == m_eff) ? '0 : wm_plus[AW-1:0];
          idx <= ham;
          s   <= ha;
          i   <= '0;
        end
      end
      cbf_pkg::S_PCHK: begin
        if (rd_data == 8'd0) begin
          if (op == cbf_pkg::OP_QUERY)  may <= 1'b0;
          if (op == cbf_pkg::OP_REMOVE) rok <= 1'b0;
        end
        {carry, s} <= s_sum;
        i          <= i + 1'b1;
        idx        <= step_red[AW-1:0];
      end
      cbf_pkg::S_PADV: if (carry) idx <= corr[AW-1:0];
      cbf_pkg::S_DONE: begin
        if (!out_valid || m_axis_tready) begin
          out_may   <= may && (op == cbf_pkg::OP_QUERY);
          out_rok   <= rok && (op == cbf_pkg::OP_REMOVE);
          out_count <= elements_next;
        end
      end
      default: ;
    endcase
  end

  // counter ram, single port with registered read
  always_ff @(posedge clk) begin
    if (mem_we) counters[mem_addr] <= mem_wdata;
    rd_data <= counters[mem_addr];
  end

  cbf_mul64 u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_p),
    .stat    (mul_st)
  );

  cbf_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (mod_dvd),
    .divisor   (m_eff),
    .remainder (mod_rem),
    .stat      (mod_st)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_count, out_rok, out_may};

  // ram is only written by the clear sweep or a probe update
  `CBF_ASSERT_NOW(a_mem_write_src, mem_we, (state == cbf_pkg::S_CLEAR || state == cbf_pkg::S_PCHK), "counter write outside sweep or probe")
  // every probe address stays inside the modulus
  `CBF_ASSERT_NOW(a_idx_range, state == cbf_pkg::S_PRD, ({1'b0, idx} < m_eff), "probe index beyond modulus")
  // probe count never runs past k
  `CBF_ASSERT_NOW(a_probe_count, state == cbf_pkg::S_PRD, (i < k_eff), "probe count beyond hash count")
  // one item at a time
  `CBF_ASSERT_NEXT(a_one_item, accept, !s_axis_tready, "ready right after a transfer")

endmodule

`default_nettype wire

// ----- bench/counting_bloom_filter_core_tb.sv -----
// ----------------------------------------------------------------------------
// counting_bloom_filter_core_tb
// self-checking bench: directed table then random keys, predicted by a local
// murmur3 double-hash model of the counter array and element count
// ----------------------------------------------------------------------------
`default_nettype none

module counting_bloom_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_LIMIT = 10000000;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic         cfg_index;
  logic [12:0]  cfg_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;   // key_low, key_high, key_length, zero pad
  logic [1:0]   s_axis_tuser;   // opcode
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [39:0]  m_axis_tdata;   // may_contain, remove_ok, element_count, zero pad

  counting_bloom_filter_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  typedef struct packed {
    logic        may_contain;
    logic        remove_ok;
    logic [31:0] element_count;
  } verdict_t;

  typedef struct {
    cbf_pkg::op_t op;
    logic [63:0]  lo;
    logic [63:0]  hi;
    logic [4:0]   len;
    logic         known;   // expected result typed in
    verdict_t     want;
  } row_t;

  // filter image kept by the bench
  logic [7:0]  filt_cnt [cbf_pkg::COUNTER_DEPTH];
  logic [31:0] filt_elems;
  logic [4:0]  probes_reg;
  logic [12:0] modulus_reg;

  verdict_t pending_verdicts[$];
  int       errors;
  longint   cycle_no;
  int       src_idle_pct;
  int       dst_idle_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_no = 0;
    forever begin
      @(posedge clk);
      cycle_no++;
      if (cycle_no > RUN_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rol(logic [63:0] v, int r);
    return (v << r) | (v >> (64 - r));
  endfunction

  function automatic logic [63:0] fmix(logic [63:0] v);
    v ^= v >> 33;
    v *= 64'hff51afd7ed558ccd;
    v ^= v >> 33;
    v *= 64'hc4ceb9fe1a85ec53;
    v ^= v >> 33;
    return v;
  endfunction

  function automatic logic [63:0] keep_bytes(logic [63:0] v, int n);
    if (n >= 8) return v;
    return v & ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  // murmur3 x64_128 first half for keys up to 16 bytes
  function automatic logic [63:0] murmur_lo_half(logic [63:0] lo, logic [63:0] hi,
                                                 int len, logic [63:0] seed);
    logic [63:0] a, b, t;
    a = seed;
    b = seed;
    if (len == 16) begin
      t = rol(lo * cbf_pkg::MM_C1, 31) * cbf_pkg::MM_C2;
      a ^= t;
      a = rol(a, 27) + b;
      a = a * 5 + 64'h52dce729;
      t = rol(hi * cbf_pkg::MM_C2, 33) * cbf_pkg::MM_C1;
      b ^= t;
      b = rol(b, 31) + a;
      b = b * 5 + 64'h38495ab5;
    end else begin
      if (len > 8)
        b ^= rol(keep_bytes(hi, len - 8) * cbf_pkg::MM_C2, 33) * cbf_pkg::MM_C1;
      if (len > 0)
        a ^= rol(keep_bytes(lo, len) * cbf_pkg::MM_C1, 31) * cbf_pkg::MM_C2;
    end
    a ^= 64'(len);
    b ^= 64'(len);
    a += b;
    b += a;
    a = fmix(a);
    b = fmix(b);
    return a + b;
  endfunction

  function automatic verdict_t apply_filter_op(cbf_pkg::op_t op, logic [63:0] lo,
                                               logic [63:0] hi, logic [4:0] len_in);
    verdict_t    v;
    int          k, len;
    logic [63:0] m, ha, hb, idx;
    v = '0;
    k = (probes_reg > cbf_pkg::MAX_PROBES) ? cbf_pkg::MAX_PROBES : probes_reg;
    m = (modulus_reg == 0) ? 1 : (modulus_reg > cbf_pkg::COUNTER_DEPTH ?
                                  cbf_pkg::COUNTER_DEPTH : modulus_reg);
    len = (len_in > cbf_pkg::KEY_BYTES) ? cbf_pkg::KEY_BYTES : len_in;
    if (op == cbf_pkg::OP_CLEAR) begin
      foreach (filt_cnt[i]) filt_cnt[i] = '0;
      filt_elems = '0;
    end else begin
      ha = murmur_lo_half(lo, hi, len, cbf_pkg::SEED_A);
      hb = murmur_lo_half(lo, hi, len, cbf_pkg::SEED_B);
      if (op == cbf_pkg::OP_INSERT) begin
        for (int i = 0; i < k; i++) begin
          idx = (ha + 64'(i) * hb) % m;
          if (filt_cnt[idx] != cbf_pkg::COUNTER_MAX) filt_cnt[idx]++;
        end
        if (filt_elems != 32'hffffffff) filt_elems++;
      end else if (op == cbf_pkg::OP_QUERY) begin
        v.may_contain = 1'b1;
        for (int i = 0; i < k; i++) begin
          idx = (ha + 64'(i) * hb) % m;
          if (filt_cnt[idx] == 0) begin
            v.may_contain = 1'b0;
            break;
          end
        end
      end else begin
        v.remove_ok = 1'b1;
        for (int i = 0; i < k; i++) begin
          idx = (ha + 64'(i) * hb) % m;
          if (filt_cnt[idx] == 0) begin
            v.remove_ok = 1'b0;
            break;
          end
          filt_cnt[idx]--;
        end
        if (v.remove_ok && filt_elems != 0) filt_elems--;
      end
    end
    v.element_count = filt_elems;
    return v;
  endfunction

  // result side: random stall and compare with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_axis_tdata);
          errors++;
        end else begin
          verdict_t w, g;
          w = pending_verdicts.pop_front();
          g.may_contain   = m_axis_tdata[0];
          g.remove_ok     = m_axis_tdata[1];
          g.element_count = m_axis_tdata[33:2];
          if (g.may_contain !== w.may_contain) begin
            $display("%0t: may_contain expected %0d actual %0d", $time,
                     w.may_contain, g.may_contain);
            errors++;
          end
          if (g.remove_ok !== w.remove_ok) begin
            $display("%0t: remove_ok expected %0d actual %0d", $time,
                     w.remove_ok, g.remove_ok);
            errors++;
          end
          if (g.element_count !== w.element_count) begin
            $display("%0t: element_count expected %0d actual %0d", $time,
                     w.element_count, g.element_count);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // one transfer on the input side, with a random gap before it
  task automatic send_item(cbf_pkg::op_t op, logic [63:0] lo, logic [63:0] hi,
                           logic [4:0] len, logic known, verdict_t want);
    verdict_t v;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, len, hi, lo};
    do @(posedge clk); while (!s_axis_tready);
    v = apply_filter_op(op, lo, hi, len);
    if (known && v !== want) begin
      $display("%0t: table row disagrees, expected %h predicted %h", $time, want, v);
      errors++;
    end
    pending_verdicts.push_back(v);
  endtask

  // idle point: drain the results and let the core finish before a register write
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(cbf_pkg::cfg_idx_t idx, logic [12:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == cbf_pkg::CFG_HASH_COUNT) probes_reg = val[4:0];
    else modulus_reg = val;
  endtask

  function automatic logic [63:0] rand64;
    return {$urandom, $urandom};
  endfunction

  // random mix: keys mostly drawn from a small pool so queries and removes hit
  task automatic random_batch(int n);
    logic [63:0]  pool_lo [8], pool_hi [8];
    logic [4:0]   pool_len [8];
    int           p, r;
    cbf_pkg::op_t op;
    for (int i = 0; i < 8; i++) begin
      pool_lo[i] = rand64();
      pool_hi[i] = rand64();
      pool_len[i] = 5'($urandom_range(16));
    end
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      op = (r < 40) ? cbf_pkg::OP_INSERT :
           (r < 70) ? cbf_pkg::OP_QUERY  :
           (r < 98) ? cbf_pkg::OP_REMOVE : cbf_pkg::OP_CLEAR;
      if ($urandom_range(9) < 8) begin
        p = $urandom_range(7);
        send_item(op, pool_lo[p], pool_hi[p], pool_len[p], 1'b0, '0);
      end else begin
        send_item(op, rand64(), rand64(), 5'($urandom_range(31)), 1'b0, '0);
      end
    end
  endtask

  row_t dir_rows[$];

  initial begin
    errors        = 0;
    src_idle_pct  = 17;
    dst_idle_pct  = 65;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = cbf_pkg::CFG_HASH_COUNT;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = cbf_pkg::OP_INSERT;
    m_axis_tready = 1'b0;
    foreach (filt_cnt[i]) filt_cnt[i] = '0;
    filt_elems  = '0;
    probes_reg  = 5'd7;
    modulus_reg = 13'd4096;

    // directed rows: known results after reset, on empty filter, and on clear
    dir_rows = '{
      '{cbf_pkg::OP_QUERY,  64'h0, 64'h0, 5'd0, 1'b1, '{1'b0, 1'b0, 32'd0}},
      '{cbf_pkg::OP_REMOVE, 64'h0, 64'h0, 5'd0, 1'b1, '{1'b0, 1'b0, 32'd0}},
      '{cbf_pkg::OP_INSERT, 64'h0, 64'h0, 5'd0, 1'b1, '{1'b0, 1'b0, 32'd1}},
      '{cbf_pkg::OP_QUERY,  64'h0, 64'h0, 5'd0, 1'b1, '{1'b1, 1'b0, 32'd1}},
      '{cbf_pkg::OP_INSERT, '1, '1, 5'd16, 1'b1, '{1'b0, 1'b0, 32'd2}},
      '{cbf_pkg::OP_INSERT, '1, '1, 5'd31, 1'b1, '{1'b0, 1'b0, 32'd3}},
      '{cbf_pkg::OP_QUERY,  '1, '1, 5'd16, 1'b1, '{1'b1, 1'b0, 32'd3}},
      '{cbf_pkg::OP_INSERT, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd8, 1'b0, '0},
      '{cbf_pkg::OP_INSERT, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd9, 1'b0, '0},
      '{cbf_pkg::OP_INSERT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 5'd15, 1'b0, '0},
      '{cbf_pkg::OP_REMOVE, '1, '1, 5'd16, 1'b0, '0},
      '{cbf_pkg::OP_REMOVE, '1, '1, 5'd16, 1'b0, '0},
      '{cbf_pkg::OP_REMOVE, '1, '1, 5'd16, 1'b0, '0},
      '{cbf_pkg::OP_QUERY,  64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 5'd1, 1'b0, '0},
      '{cbf_pkg::OP_REMOVE, 64'h0, 64'h0, 5'd0, 1'b0, '0},
      '{cbf_pkg::OP_CLEAR,  '1, '1, 5'd31, 1'b1, '{1'b0, 1'b0, 32'd0}},
      '{cbf_pkg::OP_QUERY,  64'h0, 64'h0, 5'd0, 1'b1, '{1'b0, 1'b0, 32'd0}}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // core runs its clearing sweep first; the handshake waits it out

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].lo, dir_rows[i].hi, dir_rows[i].len,
                dir_rows[i].known, dir_rows[i].want);
    drain();

    // counter saturation: one counter, many inserts
    write_reg(cbf_pkg::CFG_COUNTER_COUNT, 13'd1);
    write_reg(cbf_pkg::CFG_HASH_COUNT, 5'd16);
    for (int i = 0; i < 18; i++)
      send_item(cbf_pkg::OP_INSERT, rand64(), rand64(), 5'd16, 1'b0, '0);
    drain();
    // zero probes, out-of-range registers
    write_reg(cbf_pkg::CFG_HASH_COUNT, 5'd0);
    write_reg(cbf_pkg::CFG_COUNTER_COUNT, 13'd0);
    send_item(cbf_pkg::OP_QUERY, 64'h1, 64'h2, 5'd3, 1'b0, '0);
    send_item(cbf_pkg::OP_REMOVE, 64'h1, 64'h2, 5'd3, 1'b0, '0);
    send_item(cbf_pkg::OP_INSERT, 64'h1, 64'h2, 5'd3, 1'b0, '0);
    drain();
    write_reg(cbf_pkg::CFG_HASH_COUNT, 5'd31);
    write_reg(cbf_pkg::CFG_COUNTER_COUNT, 13'h1fff);
    random_batch(120);
    drain();

    write_reg(cbf_pkg::CFG_HASH_COUNT, 5'd1);
    write_reg(cbf_pkg::CFG_COUNTER_COUNT, 13'd4096);
    src_idle_pct = 65;
    dst_idle_pct = 17;
    random_batch(200);
    drain();

    write_reg(cbf_pkg::CFG_HASH_COUNT, 5'd7);
    write_reg(cbf_pkg::CFG_COUNTER_COUNT, 13'd61);
    src_idle_pct = 0;
    dst_idle_pct = 0;
    random_batch(200);
    drain();

    write_reg(cbf_pkg::CFG_HASH_COUNT, 5'd16);
    write_reg(cbf_pkg::CFG_COUNTER_COUNT, 13'd4095);
    random_batch(150);

    drain();
    repeat (4200) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- counting_bloom_filter_core.f -----
+incdir+design
design/cbf_pkg.sv
design/cbf_mul64.sv
design/cbf_mod.sv
design/counting_bloom_filter_core.sv
bench/counting_bloom_filter_core_tb.sv
